>>> hw/rtl/oawm_pkg.sv
`default_nettype none

package oawm_pkg;

  localparam int NumSensors = 8;
  localparam int ProxW      = 12;
  localparam int SpeedW     = 16;
  localparam int BiasW      = 11;
  localparam int LimW       = 15;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int SumW       = 15;
  localparam int AccW       = 22;
  localparam int MagW       = AccW - 1;
  localparam int QuoW       = 12;
  localparam int CutW       = SpeedW + ProxW + 1;
  localparam int CutShift   = 13;
  localparam int MixW       = SpeedW + 2;

  // x / 350 == (x * DivMul) >> DivShift for every x below 2^21
  localparam int           DivShift = 32;
  localparam int           DivMulW  = 24;
  localparam int           ProdW    = MagW + DivMulW;
  localparam logic [DivMulW-1:0] DivMul = 24'd12271336;

  localparam logic signed [7:0] WeightRight [NumSensors] =
    '{8'sd42, 8'sd59, 8'sd41, 8'sd49, 8'sd23, 8'sd57, 8'sd20, 8'sd42};
  localparam logic signed [7:0] WeightLeft [NumSensors] =
    '{-8'sd19, 8'sd23, 8'sd39, 8'sd56, 8'sd39, 8'sd41, 8'sd20, 8'sd2};

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeftBias  = 3'd0,
    CfgRightBias = 3'd1,
    CfgMaxSpeed  = 3'd2,
    CfgCrowdThr  = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [BiasW-1:0] bias_l;
    logic signed [BiasW-1:0] bias_r;
    logic [LimW-1:0]         speed_lim;
    logic [LimW-1:0]         crowd_thr;
  } cfg_t;

  // input word as laid out on tdata, sensor 0 in the lowest bits
  typedef struct packed {
    logic signed [SpeedW-1:0]              base_right;
    logic signed [SpeedW-1:0]              base_left;
    logic [NumSensors-1:0][ProxW-1:0]      prox;
  } in_t;

  typedef struct packed {
    logic signed [AccW-1:0]   acc_l;
    logic signed [AccW-1:0]   acc_r;
    logic [ProxW-1:0]         max_prox;
    logic                     crowded;
    logic signed [SpeedW-1:0] base_l;
    logic signed [SpeedW-1:0] base_r;
  } s1_t;

  typedef struct packed {
    logic [QuoW-1:0]          quo_l;
    logic                     neg_l;
    logic [QuoW-1:0]          quo_r;
    logic                     neg_r;
    logic signed [CutW-1:0]   cut_l;
    logic signed [CutW-1:0]   cut_r;
    logic                     crowded;
    logic signed [SpeedW-1:0] base_l;
    logic signed [SpeedW-1:0] base_r;
  } s2_t;

  typedef struct packed {
    logic                     crowded;
    logic signed [SpeedW-1:0] right_speed;
    logic signed [SpeedW-1:0] left_speed;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/oawm_cfg.sv
`default_nettype none

module oawm_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [oawm_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  wire logic [oawm_pkg::CfgDataW-1:0]  wr_data_i,
  output oawm_pkg::cfg_t                      cfg_o
);
  import oawm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CfgLeftBias:  cfg_d.bias_l    = wr_data_i[BiasW-1:0];
        CfgRightBias: cfg_d.bias_r    = wr_data_i[BiasW-1:0];
        CfgMaxSpeed:  cfg_d.speed_lim = wr_data_i[LimW-1:0];
        CfgCrowdThr:  cfg_d.crowd_thr = wr_data_i[LimW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bias_l    <= 11'sd66;
      cfg_q.bias_r    <= 11'sd72;
      cfg_q.speed_lim <= 15'd800;
      cfg_q.crowd_thr <= 15'd2800;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/oawm_sense.sv
`default_nettype none

module oawm_sense (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire oawm_pkg::in_t             in_i,
  input  wire logic [oawm_pkg::LimW-1:0] crowd_thr_i,
  output oawm_pkg::s1_t                  s1_o
);
  import oawm_pkg::*;

  s1_t s1_q, s1_d;

  always_comb begin
    logic signed [AccW-1:0] acc_l, acc_r, p;
    logic [SumW-1:0]        total;
    logic [ProxW-1:0]       maxr;
    acc_l = '0;
    acc_r = '0;
    total = '0;
    maxr  = '0;
    for (int i = 0; i < NumSensors; i++) begin
      p     = $signed({{(AccW-ProxW){1'b0}}, in_i.prox[i]});
      acc_r = acc_r + AccW'(WeightRight[i]) * p;
      acc_l = acc_l + AccW'(WeightLeft[i]) * p;
      total = total + SumW'(in_i.prox[i]);
      if (in_i.prox[i] > maxr) begin
        maxr = in_i.prox[i];
      end
    end
    s1_d.acc_l    = acc_l;
    s1_d.acc_r    = acc_r;
    s1_d.max_prox = maxr;
    s1_d.crowded  = total > crowd_thr_i;
    s1_d.base_l   = in_i.base_left;
    s1_d.base_r   = in_i.base_right;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

`default_nettype wire

>>> hw/rtl/oawm_divscale.sv
`default_nettype none

module oawm_divscale (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire oawm_pkg::s1_t s1_i,
  output oawm_pkg::s2_t      s2_o
);
  import oawm_pkg::*;

  s2_t s2_q, s2_d;

  logic [MagW-1:0]  mag_l, mag_r;
  logic [ProdW-1:0] prod_l, prod_r;
  logic signed [CutW-1:0] prox_s;

  // divide magnitudes by 350 through the reciprocal, sign is put back later
  assign mag_l  = s1_i.acc_l[AccW-1] ? MagW'(-s1_i.acc_l) : s1_i.acc_l[MagW-1:0];
  assign mag_r  = s1_i.acc_r[AccW-1] ? MagW'(-s1_i.acc_r) : s1_i.acc_r[MagW-1:0];
  assign prod_l = ProdW'(mag_l) * ProdW'(DivMul);
  assign prod_r = ProdW'(mag_r) * ProdW'(DivMul);
  assign prox_s = $signed({{(CutW-ProxW){1'b0}}, s1_i.max_prox});

  always_comb begin
    s2_d.quo_l   = prod_l[DivShift +: QuoW];
    s2_d.neg_l   = s1_i.acc_l[AccW-1];
    s2_d.quo_r   = prod_r[DivShift +: QuoW];
    s2_d.neg_r   = s1_i.acc_r[AccW-1];
    s2_d.cut_l   = CutW'(s1_i.base_l) * prox_s;
    s2_d.cut_r   = CutW'(s1_i.base_r) * prox_s;
    s2_d.crowded = s1_i.crowded;
    s2_d.base_l  = s1_i.base_l;
    s2_d.base_r  = s1_i.base_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

>>> hw/rtl/oawm_mix.sv
`default_nettype none

module oawm_mix (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire oawm_pkg::s2_t  s2_i,
  input  wire oawm_pkg::cfg_t cfg_i,
  output oawm_pkg::out_t      out_o
);
  import oawm_pkg::*;

  out_t out_q, out_d;

  function automatic logic signed [SpeedW-1:0] mix_wheel(
    input logic signed [SpeedW-1:0] base,
    input logic signed [CutW-1:0]   prod,
    input logic                     crowded,
    input logic [QuoW-1:0]          quo,
    input logic                     neg,
    input logic signed [BiasW-1:0]  bias,
    input logic [LimW-1:0]          lim
  );
    logic signed [CutW-1:0]   rnd;
    logic signed [SpeedW-1:0] cut;
    logic signed [MixW-1:0]   term, sum, hi;
    // shift toward zero: bias negative products before the arithmetic shift
    rnd  = prod + (prod[CutW-1] ? CutW'((1 << CutShift) - 1) : CutW'(0));
    cut  = crowded ? rnd[CutShift +: SpeedW] : '0;
    term = $signed({{(MixW-QuoW){1'b0}}, quo});
    term = neg ? -term : term;
    term = term + MixW'(bias);
    sum  = MixW'(base) - MixW'(cut) + term;
    hi   = $signed({{(MixW-LimW){1'b0}}, lim});
    if (sum > hi) begin
      sum = hi;
    end else if (sum < -hi) begin
      sum = -hi;
    end
    return sum[SpeedW-1:0];
  endfunction

  always_comb begin
    out_d.left_speed  = mix_wheel(s2_i.base_l, s2_i.cut_l, s2_i.crowded, s2_i.quo_l,
                                  s2_i.neg_l, cfg_i.bias_l, cfg_i.speed_lim);
    out_d.right_speed = mix_wheel(s2_i.base_r, s2_i.cut_r, s2_i.crowded, s2_i.quo_r,
                                  s2_i.neg_r, cfg_i.bias_r, cfg_i.speed_lim);
    out_d.crowded     = s2_i.crowded;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/obstacle_avoid_wheel_mix_top.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: prox_0..prox_7, base_left, base_right
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: left_speed, right_speed; tuser: crowded
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// three register stages: sensor sums, reciprocal and scale multiplies, mix and clamp
// one word accepted per cycle when the output is drained
// the middle stage holds the two reciprocal and the two scale multiplies, the first only
// constant weights
// reset loads the default register values and empties the pipeline; no clearing pass
// a stall on m_axis backs up stage by stage; s_axis_tready drops only with all stages full
`default_nettype none

module obstacle_avoid_wheel_mix_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output wire logic                            s_axis_tready,
  // prox_0..prox_7 (12 bits each), base_left, base_right
  input  wire logic [127:0]                    s_axis_tdata,
  output wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // left_speed, right_speed
  output wire logic [31:0]                     m_axis_tdata,
  // crowded
  output wire logic [0:0]                      m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  output wire logic                            cfg_ready_o,
  input  wire logic [oawm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [oawm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import oawm_pkg::*;

  cfg_t cfg;
  s1_t  s1;
  s2_t  s2;
  out_t res;
  in_t  in_word;

  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign v1_d = adv1 ? s_axis_tvalid : v1_q;
  assign v2_d = adv2 ? v1_q : v2_q;
  assign v3_d = adv3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_word = s_axis_tdata;

  oawm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  oawm_sense u_sense (
    .clk_i       (clk_i),
    .en_i        (adv1),
    .in_i        (in_word),
    .crowd_thr_i (cfg.crowd_thr),
    .s1_o        (s1)
  );

  oawm_divscale u_divscale (
    .clk_i (clk_i),
    .en_i  (adv2),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  oawm_mix u_mix (
    .clk_i (clk_i),
    .en_i  (adv3),
    .s2_i  (s2),
    .cfg_i (cfg),
    .out_o (res)
  );

  assign s_axis_tready = adv1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {res.right_speed, res.left_speed};
  assign m_axis_tuser  = res.crowded;
  assign cfg_ready_o   = 1'b1;

  logic signed [SpeedW:0] lim_s;
  assign lim_s = $signed({2'b00, cfg.speed_lim});

  // input stalls only when every stage holds a word and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // a word in stage two moves to the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && adv3) |=> m_axis_tvalid)
    else $error("word lost between stage two and output");

  // loaded speeds respect the clamp limit in force when they were formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && adv3) |=>
      (($signed({m_axis_tdata[15], m_axis_tdata[15:0]}) <= $past(lim_s)) &&
       ($signed({m_axis_tdata[15], m_axis_tdata[15:0]}) >= -$past(lim_s)) &&
       ($signed({m_axis_tdata[31], m_axis_tdata[31:16]}) <= $past(lim_s)) &&
       ($signed({m_axis_tdata[31], m_axis_tdata[31:16]}) >= -$past(lim_s))))
    else $error("wheel speed outside clamp limit");

  // a word in stage one is never dropped while stage two advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2) |=> v2_q)
    else $error("word lost between stage one and stage two");

endmodule

`default_nettype wire

>>> verif/obstacle_avoid_wheel_mix_top_tb.sv
`timescale 1ns / 100ps

module obstacle_avoid_wheel_mix_top_tb;

  localparam int     NumProx     = oawm_pkg::NumSensors;
  localparam longint SensDiv     = 350;
  localparam longint ScaleDiv    = 8192;
  localparam int     PhaseCount  = 8;
  localparam int     PhaseItems  = 130;
  localparam int     DrainCycles = 6;
  localparam int     CycleLimit  = 300000;
  localparam int     CfgIdxTop   = (1 << oawm_pkg::CfgIdxW) - 1;
  localparam int     FirstSpare  = int'(oawm_pkg::CfgCrowdThr) + 1;

  localparam longint RightGain [NumProx] = '{42, 59, 41, 49, 23, 57, 20, 42};
  localparam longint LeftGain  [NumProx] = '{-19, 23, 39, 56, 39, 41, 20, 2};

  // one directed word; fixed rows carry the speeds expected with reset registers
  typedef struct packed {
    logic [95:0] prox;
    logic [15:0] bl;
    logic [15:0] br;
    logic        fixed;
    logic [15:0] el;
    logic [15:0] er;
    logic        ec;
  } probe_t;

  localparam int ProbeCount = 20;
  localparam probe_t Probes [ProbeCount] = '{
    '{96'd0,                 16'h0000, 16'h0000, 1'b1, 16'd66,   16'd72,   1'b0},
    '{{8{12'hFFF}},          16'h0000, 16'h0000, 1'b1, 16'd800,  16'd800,  1'b1},
    '{96'd0,                 16'h7FFF, 16'h8000, 1'b1, 16'd800,  16'hFCE0, 1'b0},
    '{96'd0,                 16'h8000, 16'h7FFF, 1'b1, 16'hFCE0, 16'd800,  1'b0},
    // total equal to the threshold, then one above it
    '{{84'd0, 12'd2800},     16'd500,  16'hFE0C, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{84'd0, 12'd2801},     16'd500,  16'hFE0C, 1'b0, 16'd0,    16'd0,    1'b0},
    // negative left term truncates toward zero
    '{{84'd0, 12'd100},      16'h0000, 16'h0000, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{84'd0, 12'd4095},     16'h0000, 16'h0000, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 12),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 24),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 36),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 48),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 60),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 72),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{(96'hFFF << 84),       16'd300,  16'hFED4, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{8{12'hFFF}},          16'h8000, 16'h7FFF, 1'b0, 16'd0,    16'd0,    1'b0},
    // scaling of tiny negative base truncates to no change
    '{{8{12'hFFF}},          16'hFFFF, 16'h0001, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{84'd0, 12'd4000},     16'd100,  16'hFF9C, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{4{12'hAAA, 12'h555}}, 16'h5555, 16'hAAAA, 1'b0, 16'd0,    16'd0,    1'b0},
    '{{4{12'h555, 12'hAAA}}, 16'hAAAA, 16'h5555, 1'b0, 16'd0,    16'd0,    1'b0}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [127:0]                      s_axis_tdata;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [31:0]                       m_axis_tdata;
  logic [0:0]                        m_axis_tuser;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [oawm_pkg::CfgIdxW-1:0]      cfg_index_i;
  logic [oawm_pkg::CfgDataW-1:0]     cfg_data_i;

  // predictor copy of the registers
  logic signed [oawm_pkg::BiasW-1:0] bias_l;
  logic signed [oawm_pkg::BiasW-1:0] bias_r;
  logic [oawm_pkg::LimW-1:0]         speed_lim;
  logic [oawm_pkg::LimW-1:0]         crowd_thr;

  oawm_pkg::out_t speed_q [$];

  int errors;
  int cycles;
  int tx_pct;
  int rx_pct;
  int n_sent;
  int n_checked;
  int n_crowded;
  int n_settings;

  obstacle_avoid_wheel_mix_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic oawm_pkg::out_t mix_wheels(input oawm_pkg::in_t w);
    longint tot, peak, acc_l, acc_r, p, bl, br, lim;
    oawm_pkg::out_t r;
    tot   = 0;
    peak  = 0;
    acc_l = 0;
    acc_r = 0;
    for (int i = 0; i < NumProx; i++) begin
      p = w.prox[i];
      tot += p;
      if (p > peak) peak = p;
      acc_r += RightGain[i] * p;
      acc_l += LeftGain[i] * p;
    end
    acc_l = acc_l / SensDiv + longint'(bias_l);
    acc_r = acc_r / SensDiv + longint'(bias_r);
    bl = longint'(w.base_left);
    br = longint'(w.base_right);
    r.crowded = (tot > longint'(crowd_thr));
    if (r.crowded) begin
      bl = bl - (bl * peak) / ScaleDiv;
      br = br - (br * peak) / ScaleDiv;
    end
    lim = longint'(speed_lim);
    bl = bl + acc_l;
    br = br + acc_r;
    if (bl > lim) bl = lim;
    if (bl < -lim) bl = -lim;
    if (br > lim) br = lim;
    if (br < -lim) br = -lim;
    r.left_speed  = bl[15:0];
    r.right_speed = br[15:0];
    return r;
  endfunction

  function automatic oawm_pkg::in_t pick_word();
    oawm_pkg::in_t w;
    int kind, each, spot;
    kind = $urandom_range(9);
    for (int i = 0; i < NumProx; i++) w.prox[i] = 12'($urandom);
    case (kind)
      0: w.prox = '0;
      1: for (int i = 0; i < NumProx; i++) w.prox[i] = 12'hFFF;
      2: for (int i = 0; i < NumProx; i++) w.prox[i] = 12'($urandom_range(63));
      3: begin
        w.prox = '0;
        w.prox[$urandom_range(NumProx - 1)] = 12'($urandom);
      end
      4, 5: begin
        // total lands on the threshold or one either side
        each = int'(crowd_thr) / NumProx;
        for (int i = 0; i < NumProx; i++) w.prox[i] = 12'(each);
        spot = each + int'(crowd_thr) % NumProx + int'($urandom_range(2)) - 1;
        if (spot < 0) spot = 0;
        if (spot > 4095) spot = 4095;
        w.prox[0] = 12'(spot);
      end
      default: ;
    endcase
    kind = $urandom_range(7);
    w.base_left  = 16'($urandom);
    w.base_right = 16'($urandom);
    case (kind)
      0: begin
        w.base_left  = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        w.base_right = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      end
      1, 2: begin
        w.base_left  = 16'(int'($urandom_range(2000)) - 1000);
        w.base_right = 16'(int'($urandom_range(2000)) - 1000);
      end
      3: w.base_left = '0;
      default: ;
    endcase
    return w;
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic push_word(input oawm_pkg::in_t w, input bit fixed,
                           input oawm_pkg::out_t typed);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    speed_q.push_back(fixed ? typed : mix_wheels(w));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (speed_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [oawm_pkg::CfgIdxW-1:0] idx,
                           input logic [oawm_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      oawm_pkg::CfgLeftBias:  bias_l    = val[oawm_pkg::BiasW-1:0];
      oawm_pkg::CfgRightBias: bias_r    = val[oawm_pkg::BiasW-1:0];
      oawm_pkg::CfgMaxSpeed:  speed_lim = val[oawm_pkg::LimW-1:0];
      oawm_pkg::CfgCrowdThr:  crowd_thr = val[oawm_pkg::LimW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // unused upper data bits carry junk, plus one write to a spare index
  task automatic load_regs(input int bl, input int br, input int ms, input int thr);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(oawm_pkg::CfgLeftBias, {junk[15:11], bl[10:0]});
    junk = 16'($urandom);
    write_reg(oawm_pkg::CfgRightBias, {junk[15:11], br[10:0]});
    junk = 16'($urandom);
    write_reg(oawm_pkg::CfgMaxSpeed, {junk[15], ms[14:0]});
    junk = 16'($urandom);
    write_reg(oawm_pkg::CfgCrowdThr, {junk[15], thr[14:0]});
    junk = 16'($urandom);
    write_reg(oawm_pkg::CfgIdxW'($urandom_range(CfgIdxTop, FirstSpare)), junk);
    cfg_valid_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
  end

  always @(posedge clk_i) begin : rx_check
    oawm_pkg::out_t want, got;
    got.left_speed  = m_axis_tdata[15:0];
    got.right_speed = m_axis_tdata[31:16];
    got.crowded     = m_axis_tuser[0];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (speed_q.size() == 0) begin
        $display("%0t: unexpected word left %0d right %0d crowded %0d", $time,
                 $signed(got.left_speed), $signed(got.right_speed), got.crowded);
        errors++;
      end else begin
        want = speed_q.pop_front();
        n_checked++;
        if (got.crowded) n_crowded++;
        if (got.left_speed !== want.left_speed) begin
          $display("%0t: left_speed expected %0d got %0d", $time,
                   $signed(want.left_speed), $signed(got.left_speed));
          errors++;
        end
        if (got.right_speed !== want.right_speed) begin
          $display("%0t: right_speed expected %0d got %0d", $time,
                   $signed(want.right_speed), $signed(got.right_speed));
          errors++;
        end
        if (got.crowded !== want.crowded) begin
          $display("%0t: crowded expected %0d got %0d", $time, want.crowded, got.crowded);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d words still outstanding", $time, speed_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    oawm_pkg::in_t  w;
    oawm_pkg::out_t typed;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    bias_l        = 11'sd66;
    bias_r        = 11'sd72;
    speed_lim     = 15'd800;
    crowd_thr     = 15'd2800;
    errors        = 0;
    cycles        = 0;
    tx_pct        = 0;
    rx_pct        = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_crowded     = 0;
    n_settings    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // spare indexes must leave the reset values alone
    for (int i = FirstSpare; i <= CfgIdxTop; i++) begin
      write_reg(oawm_pkg::CfgIdxW'(i), 16'hFFFF);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);

    for (int r = 0; r < ProbeCount; r++) begin
      w.prox       = Probes[r].prox;
      w.base_left  = Probes[r].bl;
      w.base_right = Probes[r].br;
      typed.left_speed  = Probes[r].el;
      typed.right_speed = Probes[r].er;
      typed.crowded     = Probes[r].ec;
      push_word(w, Probes[r].fixed, typed);
    end
    drain_pipe();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: load_regs(-1000, 1000, 32767, 0);
        1: load_regs(1000, -1000, 0, 32760);
        4: load_regs(0, 0, 1, 2800);
        7: load_regs(66, 72, 800, 2800);
        default: load_regs(int'($urandom_range(2000)) - 1000,
                           int'($urandom_range(2000)) - 1000,
                           $urandom_range(32767), $urandom_range(32760));
      endcase
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 65; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 65; end
        default: begin tx_pct = 23; rx_pct = 23; end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        // in phase two the sender holds off mid-phase until the pipe is empty
        if (ph == 2 && k == PhaseItems / 2) drain_pipe();
        push_word(pick_word(), 1'b0, '0);
      end
      drain_pipe();
    end

    $display("sent %0d words over %0d register settings and four idle patterns",
             n_sent, n_settings + 1);
    $display("checked %0d results, %0d of them crowded", n_checked, n_crowded);
    if (errors == 0 && speed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
